@@ rtl/nqpe_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the NVMe queue pair engine.
package nqpe_pkg;

   localparam int ID_SLOTS      = 256;
   localparam int SQ_DEPTH_MAX  = 64;
   localparam int CQ_DEPTH_MAX  = 256;
   localparam int HANDLE_BITS   = 16;

   localparam int ID_BITS       = $clog2(ID_SLOTS);
   localparam int GROUP_SIZE    = 16;
   localparam int GROUPS        = ID_SLOTS / GROUP_SIZE;
   localparam int GRP_IDX_BITS  = $clog2(GROUP_SIZE);
   localparam int GRP_SEL_BITS  = $clog2(GROUPS);

   localparam int SQ_IDX_BITS   = $clog2(SQ_DEPTH_MAX);
   localparam int CQ_IDX_BITS   = $clog2(CQ_DEPTH_MAX);
   localparam int SQ_SIZE_BITS  = 7;
   localparam int CQ_SIZE_BITS  = 9;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 9;

   localparam int KIND_BITS     = 3;
   localparam int QIDX_BITS     = 8;
   localparam int CMDID_BITS    = 8;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_BITS-1:0] CSR_SQ_ENTRIES = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CQ_ENTRIES = 2'd1;

   // Request function codes.
   localparam logic FUNC_SUBMIT   = 1'b0;
   localparam logic FUNC_COMPLETE = 1'b1;

   // Result kinds.
   localparam logic [KIND_BITS-1:0] KIND_SQ_WRITE    = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_CPL_DELIVER = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_CQ_DOORBELL = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_NO_FREE_ID  = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_STRAY_CPL   = 3'd4;

   typedef struct packed {
      logic capture;   // latch the accepted request
      logic search;    // register per-group free slot search
      logic alloc;     // pick the slot and emit the submission entry
      logic check;     // phase check and handle memory read
      logic deliver;   // emit the completion and consume the entry
   } dp_cmd_type;

   typedef struct packed {
      logic is_complete;
      logic phase_match;
   } dp_status_type;

endpackage

@@ rtl/nqpe_ctrl.sv @@
// Sequencing state machine for the NVMe queue pair engine.
module nqpe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  nqpe_pkg::dp_status_type status,
   output nqpe_pkg::dp_cmd_type    cmd,
   output logic                   busy
);
   import nqpe_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SEARCH  = 3'd1;
   localparam logic [2:0] ST_ALLOC   = 3'd2;
   localparam logic [2:0] ST_CHECK   = 3'd3;
   localparam logic [2:0] ST_DELIVER = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // The captured function decides which path runs.
            if (status.is_complete) begin
               state_in = ST_CHECK;
            end else begin
               cmd.search = 1'b1;
               state_in   = ST_ALLOC;
            end
         end
         ST_ALLOC: begin
            cmd.alloc = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = status.phase_match ? ST_DELIVER : ST_IDLE;
         end
         ST_DELIVER: begin
            cmd.deliver = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

@@ rtl/nqpe_datapath.sv @@
// Datapath of the NVMe queue pair engine: id slots, handle memory, ring pointers and result register.
module nqpe_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  nqpe_pkg::dp_cmd_type                 cmd,
   output nqpe_pkg::dp_status_type              status,
   input  logic                                 csr_we,
   input  logic [nqpe_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [nqpe_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                                 req_func,
   input  logic [nqpe_pkg::HANDLE_BITS-1:0]     req_req_handle,
   input  logic [7:0]                           req_opcode,
   input  logic [31:0]                          req_nsid,
   input  logic [63:0]                          req_data_ptr,
   input  logic [31:0]                          req_cdw10,
   input  logic [31:0]                          req_cdw11,
   input  logic [31:0]                          req_cdw12,
   input  logic                                 req_cqe_phase,
   input  logic [nqpe_pkg::CMDID_BITS-1:0]      req_cqe_cmdid,
   input  logic [14:0]                          req_cqe_status,
   input  logic [31:0]                          req_cqe_dword0,
   output logic                                 rsp_valid,
   output logic [nqpe_pkg::KIND_BITS-1:0]       rsp_kind,
   output logic [nqpe_pkg::QIDX_BITS-1:0]       rsp_queue_index,
   output logic [nqpe_pkg::CMDID_BITS-1:0]      rsp_cmd_id,
   output logic [nqpe_pkg::HANDLE_BITS-1:0]     rsp_handle_out,
   output logic [7:0]                           rsp_opcode_out,
   output logic [31:0]                          rsp_nsid_out,
   output logic [63:0]                          rsp_data_ptr_out,
   output logic [31:0]                          rsp_cdw10_out,
   output logic [31:0]                          rsp_cdw11_out,
   output logic [31:0]                          rsp_cdw12_out,
   output logic [14:0]                          rsp_status_out,
   output logic [31:0]                          rsp_dword0_out
);
   import nqpe_pkg::*;

   // Configuration and queue state.
   logic [SQ_SIZE_BITS-1:0] sq_entries_ff;
   logic [CQ_SIZE_BITS-1:0] cq_entries_ff;
   logic [SQ_IDX_BITS-1:0]  sq_tail_ff;
   logic [SQ_IDX_BITS-1:0]  sq_tail_in;
   logic [CQ_IDX_BITS-1:0]  cq_head_ff;
   logic [CQ_IDX_BITS-1:0]  cq_head_in;
   logic                    phase_ff;
   logic                    pending_ff;
   logic [ID_SLOTS-1:0]     busy_ff;

   // Captured request.
   logic                    func_ff;
   logic [HANDLE_BITS-1:0]  handle_ff;
   logic [7:0]              opcode_ff;
   logic [31:0]             nsid_ff;
   logic [63:0]             data_ptr_ff;
   logic [31:0]             cdw10_ff;
   logic [31:0]             cdw11_ff;
   logic [31:0]             cdw12_ff;
   logic                    cqe_phase_ff;
   logic [CMDID_BITS-1:0]   cqe_cmdid_ff;
   logic [14:0]             cqe_status_ff;
   logic [31:0]             cqe_dword0_ff;

   // Two-level free slot search.
   logic [GROUPS-1:0]       grp_free_c;
   logic [GRP_IDX_BITS-1:0] grp_idx_c [GROUPS];
   logic [GROUPS-1:0]       grp_free_ff;
   logic [GRP_IDX_BITS-1:0] grp_idx_ff [GROUPS];
   logic [GRP_SEL_BITS-1:0] sel_grp_c;
   logic                    any_free_c;
   logic [ID_BITS-1:0]      slot_c;

   // Handle memory.
   logic [HANDLE_BITS-1:0]  handle_mem [ID_SLOTS];
   logic [HANDLE_BITS-1:0]  handle_rd_ff;

   // Effective ring sizes.
   logic [SQ_SIZE_BITS-1:0] sq_size_c;
   logic [CQ_SIZE_BITS-1:0] cq_size_c;
   logic [SQ_SIZE_BITS-1:0] sq_next_c;
   logic [CQ_SIZE_BITS-1:0] cq_next_c;
   logic [ID_BITS-1:0]      cpl_id_c;
   logic                    cpl_hit_c;

   // Result register.
   logic                    rsp_valid_ff;
   logic [KIND_BITS-1:0]    kind_ff;
   logic [KIND_BITS-1:0]    kind_in;
   logic [QIDX_BITS-1:0]    qidx_ff;
   logic [QIDX_BITS-1:0]    qidx_in;
   logic [CMDID_BITS-1:0]   cmd_id_ff;
   logic [CMDID_BITS-1:0]   cmd_id_in;
   logic [HANDLE_BITS-1:0]  handle_out_ff;
   logic [HANDLE_BITS-1:0]  handle_out_in;
   logic [7:0]              opcode_out_ff;
   logic [7:0]              opcode_out_in;
   logic [31:0]             nsid_out_ff;
   logic [31:0]             nsid_out_in;
   logic [63:0]             data_ptr_out_ff;
   logic [63:0]             data_ptr_out_in;
   logic [31:0]             cdw10_out_ff;
   logic [31:0]             cdw10_out_in;
   logic [31:0]             cdw11_out_ff;
   logic [31:0]             cdw11_out_in;
   logic [31:0]             cdw12_out_ff;
   logic [31:0]             cdw12_out_in;
   logic [14:0]             status_out_ff;
   logic [14:0]             status_out_in;
   logic [31:0]             dword0_out_ff;
   logic [31:0]             dword0_out_in;

   assign status.is_complete = (func_ff == FUNC_COMPLETE);
   assign status.phase_match = (cqe_phase_ff == phase_ff);

   // Out-of-range sizes clamp to the legal span.
   always_comb begin
      if (sq_entries_ff < SQ_SIZE_BITS'(2)) begin
         sq_size_c = SQ_SIZE_BITS'(2);
      end else if (sq_entries_ff > SQ_SIZE_BITS'(SQ_DEPTH_MAX)) begin
         sq_size_c = SQ_SIZE_BITS'(SQ_DEPTH_MAX);
      end else begin
         sq_size_c = sq_entries_ff;
      end
      if (cq_entries_ff < CQ_SIZE_BITS'(2)) begin
         cq_size_c = CQ_SIZE_BITS'(2);
      end else if (cq_entries_ff > CQ_SIZE_BITS'(CQ_DEPTH_MAX)) begin
         cq_size_c = CQ_SIZE_BITS'(CQ_DEPTH_MAX);
      end else begin
         cq_size_c = cq_entries_ff;
      end
      sq_next_c  = SQ_SIZE_BITS'(sq_tail_ff) + SQ_SIZE_BITS'(1);
      cq_next_c  = CQ_SIZE_BITS'(cq_head_ff) + CQ_SIZE_BITS'(1);
      sq_tail_in = (sq_next_c >= sq_size_c) ? '0 : sq_next_c[SQ_IDX_BITS-1:0];
      cq_head_in = (cq_next_c >= cq_size_c) ? '0 : cq_next_c[CQ_IDX_BITS-1:0];
   end

   // First level: lowest free bit inside each group of the busy map.
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_free_c[g] = 1'b0;
         grp_idx_c[g]  = '0;
         for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
            if (!busy_ff[g * GROUP_SIZE + b]) begin
               grp_free_c[g] = 1'b1;
               grp_idx_c[g]  = GRP_IDX_BITS'(b);
            end
         end
      end
   end

   // Second level: lowest group that has a free slot.
   always_comb begin
      sel_grp_c = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (grp_free_ff[g]) begin
            sel_grp_c = GRP_SEL_BITS'(g);
         end
      end
      any_free_c = |grp_free_ff;
      slot_c     = {sel_grp_c, grp_idx_ff[sel_grp_c]};
   end

   assign cpl_id_c  = ID_BITS'(cqe_cmdid_ff);
   assign cpl_hit_c = busy_ff[cpl_id_c];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff       <= req_func;
         handle_ff     <= req_req_handle;
         opcode_ff     <= req_opcode;
         nsid_ff       <= req_nsid;
         data_ptr_ff   <= req_data_ptr;
         cdw10_ff      <= req_cdw10;
         cdw11_ff      <= req_cdw11;
         cdw12_ff      <= req_cdw12;
         cqe_phase_ff  <= req_cqe_phase;
         cqe_cmdid_ff  <= req_cqe_cmdid;
         cqe_status_ff <= req_cqe_status;
         cqe_dword0_ff <= req_cqe_dword0;
      end
      if (cmd.search) begin
         grp_free_ff <= grp_free_c;
         grp_idx_ff  <= grp_idx_c;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.alloc && any_free_c) begin
         handle_mem[slot_c] <= handle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         handle_rd_ff <= handle_mem[cpl_id_c];
      end
   end

   // Control state: configuration, pointers, phase and the busy map.
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_entries_ff <= SQ_SIZE_BITS'(SQ_DEPTH_MAX);
         cq_entries_ff <= CQ_SIZE_BITS'(CQ_DEPTH_MAX);
         sq_tail_ff    <= '0;
         cq_head_ff    <= '0;
         phase_ff      <= 1'b1;
         pending_ff    <= 1'b0;
         busy_ff       <= '0;
      end else begin
         if (csr_we && csr_index == CSR_SQ_ENTRIES) begin
            sq_entries_ff <= csr_wdata[SQ_SIZE_BITS-1:0];
         end
         if (csr_we && csr_index == CSR_CQ_ENTRIES) begin
            cq_entries_ff <= csr_wdata[CQ_SIZE_BITS-1:0];
         end
         if (cmd.alloc && any_free_c) begin
            busy_ff[slot_c] <= 1'b1;
            sq_tail_ff      <= sq_tail_in;
         end
         if (cmd.check && !status.phase_match) begin
            pending_ff <= 1'b0;
         end
         if (cmd.deliver) begin
            if (cpl_hit_c) begin
               busy_ff[cpl_id_c] <= 1'b0;
            end
            cq_head_ff <= cq_head_in;
            if (cq_head_in == '0) begin
               phase_ff <= ~phase_ff;
            end
            pending_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (cmd.alloc) || (cmd.deliver) ||
                         (cmd.check && !status.phase_match && pending_ff);
      end
   end

   // Result payload; fields not used by a kind are zero.
   always_comb begin
      kind_in         = KIND_CQ_DOORBELL;
      qidx_in         = QIDX_BITS'(cq_head_ff);
      cmd_id_in       = '0;
      handle_out_in   = '0;
      opcode_out_in   = '0;
      nsid_out_in     = '0;
      data_ptr_out_in = '0;
      cdw10_out_in    = '0;
      cdw11_out_in    = '0;
      cdw12_out_in    = '0;
      status_out_in   = '0;
      dword0_out_in   = '0;
      if (cmd.alloc) begin
         if (any_free_c) begin
            kind_in         = KIND_SQ_WRITE;
            qidx_in         = QIDX_BITS'(sq_tail_ff);
            cmd_id_in       = CMDID_BITS'(slot_c);
            opcode_out_in   = opcode_ff;
            nsid_out_in     = nsid_ff;
            data_ptr_out_in = data_ptr_ff;
            cdw10_out_in    = cdw10_ff;
            cdw11_out_in    = cdw11_ff;
            cdw12_out_in    = cdw12_ff;
         end else begin
            kind_in       = KIND_NO_FREE_ID;
            qidx_in       = '0;
            handle_out_in = handle_ff;
         end
      end
      if (cmd.deliver) begin
         kind_in       = cpl_hit_c ? KIND_CPL_DELIVER : KIND_STRAY_CPL;
         qidx_in       = '0;
         cmd_id_in     = cqe_cmdid_ff;
         handle_out_in = cpl_hit_c ? handle_rd_ff : '0;
         status_out_in = cqe_status_ff;
         dword0_out_in = cqe_dword0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.alloc || cmd.deliver || cmd.check) begin
         kind_ff         <= kind_in;
         qidx_ff         <= qidx_in;
         cmd_id_ff       <= cmd_id_in;
         handle_out_ff   <= handle_out_in;
         opcode_out_ff   <= opcode_out_in;
         nsid_out_ff     <= nsid_out_in;
         data_ptr_out_ff <= data_ptr_out_in;
         cdw10_out_ff    <= cdw10_out_in;
         cdw11_out_ff    <= cdw11_out_in;
         cdw12_out_ff    <= cdw12_out_in;
         status_out_ff   <= status_out_in;
         dword0_out_ff   <= dword0_out_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_queue_index  = qidx_ff;
   assign rsp_cmd_id       = cmd_id_ff;
   assign rsp_handle_out   = handle_out_ff;
   assign rsp_opcode_out   = opcode_out_ff;
   assign rsp_nsid_out     = nsid_out_ff;
   assign rsp_data_ptr_out = data_ptr_out_ff;
   assign rsp_cdw10_out    = cdw10_out_ff;
   assign rsp_cdw11_out    = cdw11_out_ff;
   assign rsp_cdw12_out    = cdw12_out_ff;
   assign rsp_status_out   = status_out_ff;
   assign rsp_dword0_out   = dword0_out_ff;

endmodule

@@ rtl/nvme_queue_pair_engine.sv @@
// Top level of the host-side NVMe submission/completion queue pair engine.
//
// Usage: a request is presented on the req_ ports and taken at a rising edge
// where start is high and busy is low. A submit request (func 0) claims the
// lowest free command id and produces a submission entry write at the SQ
// tail, or a "no free id" result when all ids are outstanding. A completion
// request (func 1) carries the entry at the CQ head: on a phase match it is
// delivered (or flagged as stray) and consumed; on a mismatch a CQ head
// doorbell result is produced if entries were consumed since the last one.
// Each result appears on the rsp_ ports for exactly one cycle with rsp_valid
// high; the receiver cannot stall, so it must take every strobe.
// Sequence: a submit runs SEARCH then ALLOC; a completion runs SEARCH, CHECK
// and, on a phase match, DELIVER. The registered result strobe follows ALLOC,
// a doorbell CHECK or DELIVER. A new request is taken only back in idle.
// The submit path holds the two-level registered free-id search, the
// completion path the registered read of the handle memory. The user must
// write ring sizes on the csr_ port while idle; the block does not enforce it.
// Synchronous reset returns the block to idle with no ids outstanding,
// tail and head at zero, expected phase one and both ring sizes at maximum.
module nvme_queue_pair_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [nqpe_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [nqpe_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_func,
   input  logic [nqpe_pkg::HANDLE_BITS-1:0]     req_req_handle,
   input  logic [7:0]                           req_opcode,
   input  logic [31:0]                          req_nsid,
   input  logic [63:0]                          req_data_ptr,
   input  logic [31:0]                          req_cdw10,
   input  logic [31:0]                          req_cdw11,
   input  logic [31:0]                          req_cdw12,
   input  logic                                 req_cqe_phase,
   input  logic [nqpe_pkg::CMDID_BITS-1:0]      req_cqe_cmdid,
   input  logic [14:0]                          req_cqe_status,
   input  logic [31:0]                          req_cqe_dword0,
   output logic                                 rsp_valid,
   output logic [nqpe_pkg::KIND_BITS-1:0]       rsp_kind,
   output logic [nqpe_pkg::QIDX_BITS-1:0]       rsp_queue_index,
   output logic [nqpe_pkg::CMDID_BITS-1:0]      rsp_cmd_id,
   output logic [nqpe_pkg::HANDLE_BITS-1:0]     rsp_handle_out,
   output logic [7:0]                           rsp_opcode_out,
   output logic [31:0]                          rsp_nsid_out,
   output logic [63:0]                          rsp_data_ptr_out,
   output logic [31:0]                          rsp_cdw10_out,
   output logic [31:0]                          rsp_cdw11_out,
   output logic [31:0]                          rsp_cdw12_out,
   output logic [14:0]                          rsp_status_out,
   output logic [31:0]                          rsp_dword0_out
);
   import nqpe_pkg::*;

   // The controller only sequences; all state and results live in the datapath.
   dp_cmd_type    cmd;
   dp_status_type status;

   nqpe_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   nqpe_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_func         (req_func),
      .req_req_handle   (req_req_handle),
      .req_opcode       (req_opcode),
      .req_nsid         (req_nsid),
      .req_data_ptr     (req_data_ptr),
      .req_cdw10        (req_cdw10),
      .req_cdw11        (req_cdw11),
      .req_cdw12        (req_cdw12),
      .req_cqe_phase    (req_cqe_phase),
      .req_cqe_cmdid    (req_cqe_cmdid),
      .req_cqe_status   (req_cqe_status),
      .req_cqe_dword0   (req_cqe_dword0),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_queue_index  (rsp_queue_index),
      .rsp_cmd_id       (rsp_cmd_id),
      .rsp_handle_out   (rsp_handle_out),
      .rsp_opcode_out   (rsp_opcode_out),
      .rsp_nsid_out     (rsp_nsid_out),
      .rsp_data_ptr_out (rsp_data_ptr_out),
      .rsp_cdw10_out    (rsp_cdw10_out),
      .rsp_cdw11_out    (rsp_cdw11_out),
      .rsp_cdw12_out    (rsp_cdw12_out),
      .rsp_status_out   (rsp_status_out),
      .rsp_dword0_out   (rsp_dword0_out)
   );

endmodule
